// File: hw/rtl/bsp_pkg.sv
package bsp_pkg;

  // Configuration: beat period
  localparam int MAX_PERIOD  = 64;
  localparam int PER_MIN     = 2;
  localparam int CFG_W       = 7;
  localparam int PERIOD_RST  = 43;
  localparam int PER_W       = $clog2(MAX_PERIOD + 1);

  // Item fields
  localparam int SAMPLE_W    = 16;
  localparam int WIDX_W      = 8;
  localparam int WT_W        = 17;
  localparam int OFF_W       = 7;
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_WEIGHT = 1'b1;
  localparam logic [WT_W-1:0] WEIGHT_ONE = WT_W'(65536);

  // Storage geometry
  localparam int HIST_DEPTH  = 2 * MAX_PERIOD;
  localparam int HIST_AW     = $clog2(HIST_DEPTH);
  localparam int WT_DEPTH    = 2 * MAX_PERIOD + 1;
  localparam int WT_AW       = $clog2(WT_DEPTH);
  localparam int PRED_AW     = $clog2(MAX_PERIOD);
  localparam int D_W         = $clog2(2 * MAX_PERIOD + 1);

  // Scores are unsigned Q16.8
  localparam int SCORE_W     = 24;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
  localparam int FRAC_W      = 16;
  localparam int PROD_W      = WT_W + SCORE_W;
  localparam int ROUND_HALF  = 32768;

  // New score = num / 10 via reciprocal multiply (num holds the +5), exact below 2^32
  localparam int NUM_W       = 28;
  localparam int RECIP_W     = 32;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 32'hCCCC_CCCD;
  localparam int DIV_SHIFT   = 35;
  localparam int QP_W        = NUM_W + RECIP_W;
  localparam int ROUND_TEN   = 5;

  typedef enum logic [1:0] {
    SRC_PAST,
    SRC_PRES,
    SRC_PRED
  } src_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV,
    ST_PRES,
    ST_PRED,
    ST_DONE
  } state_e;

  typedef struct packed {
    src_e               src;
    logic [HIST_AW-1:0] hist_idx;
    logic [PRED_AW-1:0] pred_addr;
    logic [WT_AW-1:0]   wt_addr;
  } store_rd_t;

  typedef struct packed {
    logic               hist_push;
    logic               pres_we;
    logic [SCORE_W-1:0] pres_data;
    logic               pred_we;
    logic [PRED_AW-1:0] pred_addr;
    logic [SCORE_W-1:0] pred_data;
    logic               wt_we;
    logic [WT_AW-1:0]   wt_addr;
    logic [WT_W-1:0]    wt_data;
  } store_wr_t;

  typedef struct packed {
    logic issue;
    logic clear;
  } mac_ctl_t;

endpackage

// File: hw/rtl/bsp_store.sv
module bsp_store import bsp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  store_wr_t          wr_i,
  input  store_rd_t          rd_i,
  output logic [WT_W-1:0]    weight_o,
  output logic [SCORE_W-1:0] score_o
);

  logic [SCORE_W-1:0]    hist_mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] hist_vld_q;
  logic [HIST_AW-1:0]    head_q, head_d;
  logic [SCORE_W-1:0]    pred_mem [MAX_PERIOD];
  logic [WT_W-1:0]       wt_mem [WT_DEPTH];
  logic [WT_DEPTH-1:0]   wt_vld_q;
  logic [SCORE_W-1:0]    present_q;

  logic [HIST_AW:0]      hist_sum;
  logic [HIST_AW-1:0]    hist_raddr;

  logic [SCORE_W-1:0]    hist_rd_q, pred_rd_q, pres_rd_q;
  logic                  hist_vld_rd_q;
  logic [WT_W-1:0]       wt_rd_q;
  logic                  wt_vld_rd_q;
  src_e                  src_q;

  // Newest history entry sits at head; a push moves head down by one
  assign head_d = (head_q == '0) ? HIST_AW'(HIST_DEPTH - 1) : head_q - 1'b1;

  // Map a logical age onto the circular buffer
  assign hist_sum   = {1'b0, head_q} + {1'b0, rd_i.hist_idx};
  assign hist_raddr = (hist_sum >= HIST_DEPTH) ? HIST_AW'(hist_sum - HIST_DEPTH)
                                               : hist_sum[HIST_AW-1:0];

  // Control state: head pointer, valid bits, present score
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      hist_vld_q <= '0;
      wt_vld_q   <= '0;
      present_q  <= '0;
    end else begin
      if (wr_i.hist_push) begin
        head_q             <= head_d;
        hist_vld_q[head_d] <= 1'b1;
      end
      if (wr_i.wt_we) begin
        wt_vld_q[wr_i.wt_addr] <= 1'b1;
      end
      if (wr_i.pres_we) begin
        present_q <= wr_i.pres_data;
      end
    end
  end

  // Write and read the arrays, read data registered
  always_ff @(posedge clk_i) begin
    if (wr_i.hist_push) begin
      hist_mem[head_d] <= present_q;
    end
    if (wr_i.pred_we) begin
      pred_mem[wr_i.pred_addr] <= wr_i.pred_data;
    end
    if (wr_i.wt_we) begin
      wt_mem[wr_i.wt_addr] <= wr_i.wt_data;
    end
    hist_rd_q     <= hist_mem[hist_raddr];
    hist_vld_rd_q <= hist_vld_q[hist_raddr];
    pred_rd_q     <= pred_mem[rd_i.pred_addr];
    wt_rd_q       <= wt_mem[rd_i.wt_addr];
    wt_vld_rd_q   <= wt_vld_q[rd_i.wt_addr];
    pres_rd_q     <= present_q;
    src_q         <= rd_i.src;
  end

  // Weight and history entries never written read as zero
  assign weight_o = wt_vld_rd_q ? wt_rd_q : '0;

  always_comb begin
    case (src_q)
      SRC_PAST: score_o = hist_vld_rd_q ? hist_rd_q : '0;
      SRC_PRES: score_o = pres_rd_q;
      SRC_PRED: score_o = pred_rd_q;
      default:  score_o = '0;
    endcase
  end

endmodule

// File: hw/rtl/bsp_mac.sv
module bsp_mac import bsp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mac_ctl_t           ctl_i,
  input  logic [WT_W-1:0]    weight_i,
  input  logic [SCORE_W-1:0] score_i,
  output logic [SCORE_W-1:0] best_o,
  output logic               busy_o
);

  logic                       rd_vld_q, mul_vld_q;
  logic [PROD_W-1:0]          prod_q;
  logic [SCORE_W-1:0]         best_q;
  logic [PROD_W:0]            rnd;
  logic [PROD_W-FRAC_W:0]     scaled;
  logic [SCORE_W-1:0]         wscore;

  // Round half up, drop the weight fraction, saturate
  assign rnd    = {1'b0, prod_q} + (PROD_W + 1)'(ROUND_HALF);
  assign scaled = rnd[PROD_W:FRAC_W];
  assign wscore = (scaled > (PROD_W - FRAC_W + 1)'(SCORE_MAX)) ? SCORE_MAX
                                                              : scaled[SCORE_W-1:0];

  // Track read, multiply and compare stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      mul_vld_q <= 1'b0;
      best_q    <= '0;
    end else begin
      rd_vld_q  <= ctl_i.issue;
      mul_vld_q <= rd_vld_q;
      if (ctl_i.clear) begin
        best_q <= '0;
      end else if (mul_vld_q && (wscore > best_q)) begin
        best_q <= wscore;
      end
    end
  end

  // Multiply weight by score
  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      prod_q <= weight_i * score_i;
    end
  end

  assign best_o = best_q;
  assign busy_o = rd_vld_q | mul_vld_q;

endmodule

// File: hw/rtl/beat_score_predictor_unit.sv
// Channel | Direction | Handshake                  | Payload
// in      | input     | in_valid_i / in_ready_o    | opcode_i, odf_sample_i,
//         |           |                            | weight_index_i, weight_value_i
// out     | output    | out_valid_o / out_ready_i  | predicted_offset_o
// cfg     | input     | cfg_we_i, no wait          | cfg_wdata_i (beat period)
//
// A weight load is written from the idle state. For a detection sample, P is the
// clamped beat period: one shared multiply-round-compare unit steps once per cycle
// over the offsets floor(P/2) to 2P of each of the P+1 scores.
// Reset clears the score history, weight table and present score at once.
// The output register holds a result while out_ready_i is low; the block
// takes the next item meanwhile but cannot finish it until that result leaves.
module beat_score_predictor_unit import bsp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                opcode_i,
  input  logic [SAMPLE_W-1:0] odf_sample_i,
  input  logic [WIDX_W-1:0]   weight_index_i,
  input  logic [WT_W-1:0]     weight_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OFF_W-1:0]    predicted_offset_o
);

  state_e              state_q, state_d;
  logic [CFG_W-1:0]    beat_period_q;
  logic [PER_W-1:0]    p_eff;
  logic [PER_W-1:0]    p_q, p_d;
  logic [PER_W-1:0]    m_q, m_d;
  logic [D_W-1:0]      d_q, d_d;
  logic [D_W-1:0]      m_ext, d_lo, d_hi;
  logic [SAMPLE_W-1:0] sample_q, sample_d;
  logic [SCORE_W-1:0]  best_val_q, best_val_d;
  logic [PER_W-1:0]    best_off_q, best_off_d;
  logic [QP_W-1:0]     quot_prod_q, quot_prod_d;
  logic [NUM_W-1:0]    num;
  logic [QP_W-DIV_SHIFT-1:0] quot;
  logic                out_valid_q, out_valid_d;
  logic [OFF_W-1:0]    out_off_q, out_off_d;
  logic                in_xfer, out_free;

  store_rd_t           rd;
  store_wr_t           wr;
  mac_ctl_t            mac_ctl;
  logic [WT_W-1:0]     weight;
  logic [SCORE_W-1:0]  score;
  logic [SCORE_W-1:0]  best;
  logic                mac_busy;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;

  // Clamp the configured period
  always_comb begin
    if (beat_period_q < CFG_W'(PER_MIN)) begin
      p_eff = PER_W'(PER_MIN);
    end else if (beat_period_q > CFG_W'(MAX_PERIOD)) begin
      p_eff = PER_W'(MAX_PERIOD);
    end else begin
      p_eff = PER_W'(beat_period_q);
    end
  end

  assign m_ext = D_W'(m_q);
  assign d_lo  = D_W'(p_q >> 1);
  assign d_hi  = D_W'({p_q, 1'b0});

  // New present score numerator: (sample << 8) + 9 * best + 5
  assign num  = NUM_W'({sample_q, 8'b0}) + NUM_W'({best, 3'b0}) + NUM_W'(best)
              + NUM_W'(ROUND_TEN);
  assign quot = quot_prod_q[QP_W-1:DIV_SHIFT];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && (opcode_i == OP_SAMPLE)) state_d = ST_PUSH;
      end
      ST_PUSH:  state_d = ST_SCAN;
      ST_SCAN: begin
        if (d_q == d_hi) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!mac_busy) state_d = (m_q == '0) ? ST_DIV : ST_PRED;
      end
      ST_DIV:   state_d = ST_PRES;
      ST_PRES:  state_d = ST_SCAN;
      ST_PRED:  state_d = (m_q == p_q) ? ST_DONE : ST_SCAN;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    p_d         = p_q;
    m_d         = m_q;
    d_d         = d_q;
    sample_d    = sample_q;
    best_val_d  = best_val_q;
    best_off_d  = best_off_q;
    quot_prod_d = quot_prod_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_off_d   = out_off_q;
    mac_ctl     = '0;
    wr          = '0;

    // Read addresses for the current offset pair
    rd.wt_addr   = WT_AW'(d_q);
    rd.hist_idx  = HIST_AW'(d_q - m_ext - 1'b1);
    rd.pred_addr = PRED_AW'(m_ext - d_q - 1'b1);
    if (d_q > m_ext) begin
      rd.src = SRC_PAST;
    end else if (d_q == m_ext) begin
      rd.src = SRC_PRES;
    end else begin
      rd.src = SRC_PRED;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (opcode_i == OP_WEIGHT) begin
            wr.wt_we   = (weight_index_i < WIDX_W'(WT_DEPTH));
            wr.wt_addr = WT_AW'(weight_index_i);
            wr.wt_data = (weight_value_i > WEIGHT_ONE) ? WEIGHT_ONE : weight_value_i;
          end else begin
            sample_d = odf_sample_i;
            p_d      = p_eff;
          end
        end
      end
      ST_PUSH: begin
        wr.hist_push  = 1'b1;
        m_d           = '0;
        d_d           = d_lo;
        best_val_d    = '0;
        best_off_d    = '0;
        mac_ctl.clear = 1'b1;
      end
      ST_SCAN: begin
        mac_ctl.issue = 1'b1;
        d_d           = d_q + 1'b1;
      end
      ST_DIV: begin
        quot_prod_d = num * DIV_RECIP;
      end
      ST_PRES: begin
        wr.pres_we    = 1'b1;
        wr.pres_data  = (quot > (QP_W - DIV_SHIFT)'(SCORE_MAX)) ? SCORE_MAX
                                                               : quot[SCORE_W-1:0];
        m_d           = PER_W'(1);
        d_d           = d_lo;
        mac_ctl.clear = 1'b1;
      end
      ST_PRED: begin
        wr.pred_we    = 1'b1;
        wr.pred_addr  = PRED_AW'(m_q - 1'b1);
        wr.pred_data  = best;
        // Later offsets win ties
        if (best >= best_val_q) begin
          best_val_d = best;
          best_off_d = m_q;
        end
        m_d           = m_q + 1'b1;
        d_d           = d_lo;
        mac_ctl.clear = 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_off_d   = OFF_W'(best_off_q);
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      beat_period_q <= CFG_W'(PERIOD_RST);
      out_valid_q   <= 1'b0;
      m_q           <= '0;
      d_q           <= '0;
      p_q           <= PER_W'(PER_MIN);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      m_q         <= m_d;
      d_q         <= d_d;
      p_q         <= p_d;
      if (cfg_we_i) begin
        beat_period_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    sample_q    <= sample_d;
    best_val_q  <= best_val_d;
    best_off_q  <= best_off_d;
    quot_prod_q <= quot_prod_d;
    out_off_q   <= out_off_d;
  end

  bsp_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .rd_i     (rd),
    .weight_o (weight),
    .score_o  (score)
  );

  bsp_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mac_ctl),
    .weight_i (weight),
    .score_i  (score),
    .best_o   (best),
    .busy_o   (mac_busy)
  );

  assign out_valid_o        = out_valid_q;
  assign predicted_offset_o = out_off_q;

endmodule
